FILE: src/mfr_pkg.sv
package mfr_pkg;

    localparam logic [7:0] START_BYTE       = 8'h68;
    localparam logic [7:0] METER_TYPE_RST   = 8'h20;
    localparam logic [7:0] EXP_CONTROL_RST  = 8'h81;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_METER_TYPE       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CONTROL = 1'b1;

    // last address byte and the fixed part ahead of the data bytes
    localparam logic [8:0] POS_LAST_ADDR = 9'd8;
    localparam logic [8:0] POS_DATA_BASE = 9'd10;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_ADDR  = 8'b0000_0010,
        PH_CTRL  = 8'b0000_0100,
        PH_LEN   = 8'b0000_1000,
        PH_DATA  = 8'b0001_0000,
        PH_SUM   = 8'b0010_0000,
        PH_TRAIL = 8'b0100_0000,
        PH_ERR   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] meter_type;
        logic [7:0] expected_control;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        in_frame;
        logic [8:0]  byte_position;
        logic        frame_end;
        logic        checksum_ok;
        logic        control_error;
        logic [15:0] error_total;
        logic [15:0] checksum_error_total;
    } t_out_item;

endpackage

FILE: src/mfr_in_if.sv
interface mfr_in_if;
    logic               valid;
    logic               ready;
    mfr_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/mfr_out_if.sv
interface mfr_out_if;
    logic               valid;
    logic               ready;
    mfr_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/mfr_deframer.sv
module mfr_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  mfr_pkg::t_cfg      i_cfg,
    output mfr_pkg::t_out_item o_result
);
    import mfr_pkg::*;

    t_phase      r_phase,       n_phase;
    logic        r_start_seen,  n_start_seen;
    logic [8:0]  r_byte_count,  n_byte_count;
    logic [7:0]  r_data_length, n_data_length;
    logic [7:0]  r_running_sum, n_running_sum;
    logic        r_sum_matched, n_sum_matched;
    logic [15:0] r_err_cnt,     n_err_cnt;
    logic [15:0] r_sum_err_cnt, n_sum_err_cnt;

    logic        inf, fend, ok, cerr;
    logic [8:0]  pos;
    logic [7:0]  sum_plus;
    logic [8:0]  data_last;

    assign sum_plus  = r_running_sum + i_byte;
    assign data_last = POS_DATA_BASE + {1'b0, r_data_length};

    always_comb begin
        n_phase       = r_phase;
        n_start_seen  = r_start_seen;
        n_byte_count  = r_byte_count;
        n_data_length = r_data_length;
        n_running_sum = r_running_sum;
        n_sum_matched = r_sum_matched;
        n_err_cnt     = r_err_cnt;
        n_sum_err_cnt = r_sum_err_cnt;
        inf  = 1'b1;
        fend = 1'b0;
        ok   = 1'b0;
        cerr = 1'b0;
        pos  = r_byte_count;
        unique case (r_phase)
            PH_IDLE: begin
                // type byte wins over a start byte when armed
                pos = '0;
                inf = 1'b0;
                if (r_start_seen && i_byte == i_cfg.meter_type) begin
                    inf           = 1'b1;
                    pos           = 9'd1;
                    n_running_sum = sum_plus;
                    n_byte_count  = 9'd2;
                    n_start_seen  = 1'b0;
                    n_phase       = PH_ADDR;
                end else if (i_byte == START_BYTE) begin
                    inf           = 1'b1;
                    n_running_sum = START_BYTE;
                    n_byte_count  = 9'd1;
                    n_start_seen  = 1'b1;
                end
            end
            PH_ADDR: begin
                n_running_sum = sum_plus;
                n_byte_count  = r_byte_count + 9'd1;
                if (r_byte_count >= POS_LAST_ADDR) n_phase = PH_CTRL;
            end
            PH_CTRL: begin
                n_running_sum = sum_plus;
                n_byte_count  = r_byte_count + 9'd1;
                n_phase       = (i_byte == i_cfg.expected_control) ? PH_LEN : PH_ERR;
            end
            PH_LEN: begin
                n_running_sum = sum_plus;
                n_data_length = i_byte;
                n_byte_count  = r_byte_count + 9'd1;
                n_phase       = (i_byte == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                n_running_sum = sum_plus;
                n_byte_count  = r_byte_count + 9'd1;
                if (r_byte_count >= data_last) n_phase = PH_SUM;
            end
            PH_SUM: begin
                n_sum_matched = (i_byte == r_running_sum);
                n_byte_count  = r_byte_count + 9'd1;
                n_phase       = PH_TRAIL;
            end
            PH_TRAIL: begin
                fend = 1'b1;
                ok   = r_sum_matched;
                if (!r_sum_matched) n_sum_err_cnt = r_sum_err_cnt + 16'd1;
                n_byte_count = '0;
                n_phase      = PH_IDLE;
            end
            PH_ERR: begin
                fend          = 1'b1;
                cerr          = 1'b1;
                n_err_cnt     = r_err_cnt + 16'd1;
                n_sum_err_cnt = r_sum_err_cnt + 16'd1;
                n_byte_count  = '0;
                n_phase       = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.frame_byte           = i_byte;
        o_result.in_frame             = inf;
        o_result.byte_position        = pos;
        o_result.frame_end            = fend;
        o_result.checksum_ok          = ok;
        o_result.control_error        = cerr;
        o_result.error_total          = n_err_cnt;
        o_result.checksum_error_total = n_sum_err_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_start_seen  <= 1'b0;
            r_byte_count  <= '0;
            r_data_length <= '0;
            r_running_sum <= '0;
            r_sum_matched <= 1'b0;
            r_err_cnt     <= '0;
            r_sum_err_cnt <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_start_seen  <= n_start_seen;
            r_byte_count  <= n_byte_count;
            r_data_length <= n_data_length;
            r_running_sum <= n_running_sum;
            r_sum_matched <= n_sum_matched;
            r_err_cnt     <= n_err_cnt;
            r_sum_err_cnt <= n_sum_err_cnt;
        end
    end

endmodule

FILE: src/meter_frame_receiver.sv
// Meter reply deframer. Each input item is one received serial byte; each
// byte yields exactly one result item that echoes it with its frame position,
// frame-end and checksum flags and the running error totals. A frame is the
// start byte 0x68, the configured meter type byte, seven address bytes, the
// control byte, an unsigned length byte L, L data bytes, a checksum (mod-256
// sum of all earlier bytes) and a trailer: 13+L bytes. A wrong control byte
// aborts the frame on the following byte and counts in both error totals.
// Throughput is one item per clock while the result side is ready: the byte
// sits in an input register, the deframer state update is a single short step
// (one 8-bit add and a 9-bit compare), and the result lands in an output
// register. Write configuration only while the block is idle; index 0 is
// meter_type (reset 0x20), index 1 is expected_control (reset 0x81).
module meter_frame_receiver (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    mfr_in_if.sink                           i_rx,
    mfr_out_if.source                        o_frm
);
    import mfr_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item step_result;
    logic      advance;

    // move the held byte forward when the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || o_frm.ready);
    assign i_rx.ready = !r_in_valid || advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.meter_type       <= METER_TYPE_RST;
            r_cfg.expected_control <= EXP_CONTROL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_METER_TYPE:       r_cfg.meter_type       <= i_cfg_data;
                CFG_EXPECTED_CONTROL: r_cfg.expected_control <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register: hold the byte until the deframer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in <= i_rx.data;
        end
    end

    mfr_deframer u_deframer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in.rx_byte),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // result register: drop valid once taken, refill on each advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_frm.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_frm.valid = r_out_valid;
    assign o_frm.data  = r_out;

    // an empty result slot never blocks the input side
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_rx.ready)
        else $error("input stalled with empty result slot");

    // an abort on the control byte is always a frame end without a good checksum
    a_ctrl_err_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.control_error) |-> (r_out.frame_end && !r_out.checksum_ok))
        else $error("control error without frame end");

    // bytes outside a frame carry no position and end nothing
    a_noise_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.in_frame) |->
            (r_out.byte_position == 9'd0 && !r_out.frame_end))
        else $error("out-of-frame byte carries frame info");

    // the control error total steps by exactly this result's control error
    a_err_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_out_valid) |=>
            (r_out.error_total == $past(r_out.error_total) + 16'(r_out.control_error)))
        else $error("error total out of step");

endmodule

FILE: bench/meter_frame_receiver_tb.sv
`timescale 1ns / 100ps

module meter_frame_receiver_tb;

    import mfr_pkg::*;

    // Generous ceiling on run time: the slowest legal run stays well below it.
    localparam int CYCLE_LIMIT   = 200000;
    // Bytes queued per configuration setting.
    localparam int PHASE_BYTES   = 225;
    localparam int SETTING_COUNT = 6;

    // Ways a generated frame can be damaged.
    typedef enum {FLAW_NONE, FLAW_CONTROL, FLAW_CHECKSUM, FLAW_CUT} t_flaw;

    // One byte for the serial side. When the expected result is obvious,
    // it is typed in with the byte and checked in place of the prediction.
    typedef struct {
        logic [7:0] rx_byte;
        bit         typed;
        t_out_item  want;
    } t_line_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    mfr_in_if  rx_if ();
    mfr_out_if frm_if ();

    meter_frame_receiver i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx        (rx_if),
        .o_frm       (frm_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bytes waiting to go out, and echoes waiting to come back.
    t_line_byte tx_bytes [$];
    t_out_item  pending_echoes [$];

    int mismatches = 0;
    int cycles     = 0;
    // Chance in percent per cycle that an idle burst starts on either side.
    int idle_pct   = 0;
    int gap_left   = 0;
    int stall_left = 0;

    // Deframer state as the block should hold it.
    t_phase      prd_phase;
    logic        prd_armed;
    logic [8:0]  prd_count;
    logic [7:0]  prd_len;
    logic [7:0]  prd_sum;
    logic        prd_matched;
    logic [15:0] prd_ctrl_errs;
    logic [15:0] prd_sum_errs;
    // Configuration as last written.
    logic [7:0]  cfg_type;
    logic [7:0]  cfg_ctrl;

    // Advance the deframer by one byte and return the echo it must produce.
    function automatic t_out_item deframe_byte(input logic [7:0] b);
        t_out_item r;
        r = '0;
        r.frame_byte = b;
        // Every byte inside a frame is taken at the current position.
        if (prd_phase != PH_IDLE) begin
            r.in_frame      = 1'b1;
            r.byte_position = prd_count;
            prd_count       = prd_count + 9'd1;
        end
        case (prd_phase)
            PH_IDLE: begin
                // An armed type byte wins over a start byte of the same value.
                if (prd_armed && b == cfg_type) begin
                    r.in_frame      = 1'b1;
                    r.byte_position = 9'd1;
                    prd_sum         = prd_sum + b;
                    prd_count       = 9'd2;
                    prd_armed       = 1'b0;
                    prd_phase       = PH_ADDR;
                end else if (b == START_BYTE) begin
                    r.in_frame = 1'b1;
                    prd_sum    = START_BYTE;
                    prd_count  = 9'd1;
                    prd_armed  = 1'b1;
                end
            end
            PH_ADDR: begin
                prd_sum = prd_sum + b;
                if (r.byte_position >= POS_LAST_ADDR) prd_phase = PH_CTRL;
            end
            PH_CTRL: begin
                prd_sum   = prd_sum + b;
                prd_phase = (b == cfg_ctrl) ? PH_LEN : PH_ERR;
            end
            PH_LEN: begin
                prd_sum   = prd_sum + b;
                prd_len   = b;
                prd_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
                prd_sum = prd_sum + b;
                if (r.byte_position >= POS_DATA_BASE + 9'(prd_len)) prd_phase = PH_SUM;
            end
            PH_SUM: begin
                prd_matched = (b == prd_sum);
                prd_phase   = PH_TRAIL;
            end
            PH_TRAIL: begin
                r.frame_end   = 1'b1;
                r.checksum_ok = prd_matched;
                if (!prd_matched) prd_sum_errs = prd_sum_errs + 16'd1;
                prd_count = '0;
                prd_phase = PH_IDLE;
            end
            default: begin
                // Byte after a wrong control byte: abort and count twice.
                r.frame_end     = 1'b1;
                r.control_error = 1'b1;
                prd_ctrl_errs   = prd_ctrl_errs + 16'd1;
                prd_sum_errs    = prd_sum_errs + 16'd1;
                prd_count       = '0;
                prd_phase       = PH_IDLE;
            end
        endcase
        r.error_total          = prd_ctrl_errs;
        r.checksum_error_total = prd_sum_errs;
        return r;
    endfunction

    function automatic t_line_byte plain_row(input logic [7:0] b);
        t_line_byte row;
        row.rx_byte = b;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic t_line_byte known_row(input logic [7:0] b, input logic inf,
                                             input logic [8:0] pos, input logic fend,
                                             input logic ok, input logic cerr,
                                             input logic [15:0] ctrl_errs,
                                             input logic [15:0] sum_errs);
        t_line_byte row;
        row.rx_byte                   = b;
        row.typed                     = 1'b1;
        row.want.frame_byte           = b;
        row.want.in_frame             = inf;
        row.want.byte_position        = pos;
        row.want.frame_end            = fend;
        row.want.checksum_ok          = ok;
        row.want.control_error        = cerr;
        row.want.error_total          = ctrl_errs;
        row.want.checksum_error_total = sum_errs;
        return row;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), plain_row(b));
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Build one frame under the current setting, optionally damaged.
    task automatic queue_frame(input int len, input t_flaw flaw);
        logic [7:0] frame_bytes [$];
        logic [7:0] sum;
        int keep;
        frame_bytes.insert(frame_bytes.size(), START_BYTE);
        frame_bytes.insert(frame_bytes.size(), cfg_type);
        repeat (7) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
        if (flaw == FLAW_CONTROL) begin
            // Wrong control byte, then the byte that aborts the frame.
            frame_bytes.insert(frame_bytes.size(), cfg_ctrl ^ 8'($urandom_range(1, 255)));
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
        end else begin
            frame_bytes.insert(frame_bytes.size(), cfg_ctrl);
            frame_bytes.insert(frame_bytes.size(), 8'(len));
            repeat (len) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
            sum = '0;
            foreach (frame_bytes[k]) sum = sum + frame_bytes[k];
            if (flaw == FLAW_CHECKSUM) sum = sum ^ 8'($urandom_range(1, 255));
            frame_bytes.insert(frame_bytes.size(), sum);
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
        end
        // A cut frame stops short and the next frame runs into it.
        keep = (flaw == FLAW_CUT) ? $urandom_range(1, frame_bytes.size() - 1)
                                  : frame_bytes.size();
        for (int k = 0; k < keep; k++) push_byte(frame_bytes[k]);
    endtask

    // Mostly short well-formed frames, a few long ones, some damage and noise.
    task automatic queue_random_frame();
        int pick;
        int len;
        t_flaw flaw;
        pick = $urandom_range(99);
        if (pick < 4) len = 255;
        else if (pick < 10) len = $urandom_range(7, 254);
        else len = $urandom_range(0, 6);
        pick = $urandom_range(99);
        if (pick < 8) flaw = FLAW_CONTROL;
        else if (pick < 18) flaw = FLAW_CHECKSUM;
        else if (pick < 24) flaw = FLAW_CUT;
        else flaw = FLAW_NONE;
        if ($urandom_range(99) < 25) repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
        if ($urandom_range(99) < 10) push_byte(START_BYTE);
        queue_frame(len, flaw);
    endtask

    // Poll on the falling edge so queue updates at the rising edge are settled.
    task automatic wait_drained();
        while (tx_bytes.size() != 0 || pending_echoes.size() != 0) @(negedge i_clk);
    endtask

    // Write one register; the block takes it at the edge after the strobe goes up.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_METER_TYPE) cfg_type = value;
        else cfg_ctrl = value;
    endtask

    // Both handshakes in one process: take accepted bytes into the prediction,
    // check accepted echoes, then pick the next valid and ready.
    always @(posedge i_clk) begin : handshakes
        t_line_byte row;
        t_out_item  predicted;
        t_out_item  want;
        t_out_item  got;
        if (i_rst_n && rx_if.valid && rx_if.ready) begin
            row       = tx_bytes.pop_front();
            predicted = deframe_byte(row.rx_byte);
            pending_echoes.insert(pending_echoes.size(), row.typed ? row.want : predicted);
        end
        if (i_rst_n && frm_if.valid === 1'b1 && frm_if.ready) begin
            got = frm_if.data;
            if (pending_echoes.size() == 0) begin
                $error("echo of byte %0h with no byte pending", got.frame_byte);
                mismatches++;
            end else begin
                want = pending_echoes.pop_front();
                check_field("frame_byte", 16'(want.frame_byte), 16'(got.frame_byte));
                check_field("in_frame", 16'(want.in_frame), 16'(got.in_frame));
                check_field("byte_position", 16'(want.byte_position), 16'(got.byte_position));
                check_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
                check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
                check_field("control_error", 16'(want.control_error), 16'(got.control_error));
                check_field("error_total", want.error_total, got.error_total);
                check_field("checksum_error_total", want.checksum_error_total,
                            got.checksum_error_total);
            end
        end
        // Hold a byte that is offered but not yet taken.
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!(rx_if.valid && !rx_if.ready)) begin
            if (gap_left > 0) begin
                gap_left--;
                rx_if.valid <= 1'b0;
            end else if (tx_bytes.size() != 0 && idle_pct != 0
                         && $urandom_range(99) < idle_pct) begin
                gap_left = $urandom_range(8);
                rx_if.valid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
                rx_if.valid        <= 1'b1;
                rx_if.data.rx_byte <= tx_bytes[0].rx_byte;
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
        // Stall the echo side in bursts of the same length range.
        if (stall_left > 0) begin
            stall_left--;
            frm_if.ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(8);
            frm_if.ready <= 1'b0;
        end else begin
            frm_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[meter_frame_receiver] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_line_byte opening_rows [$];
        logic [7:0] set_type [SETTING_COUNT];
        logic [7:0] set_ctrl [SETTING_COUNT];
        int         set_idle [SETTING_COUNT];

        // Settings: reset values, start byte as type, all ones, all zeros as
        // type, a random one, then the reset values written back.
        set_type = '{METER_TYPE_RST, START_BYTE, 8'hff, 8'h00, 8'($urandom_range(255)),
                     METER_TYPE_RST};
        set_ctrl = '{EXP_CONTROL_RST, 8'h00, 8'hff, 8'($urandom_range(255)),
                     8'($urandom_range(255)), EXP_CONTROL_RST};
        // The second setting runs without idling; the last one as well.
        set_idle = '{25, 0, 40, 10, 60, 0};

        prd_phase     = PH_IDLE;
        prd_armed     = 1'b0;
        prd_count     = '0;
        prd_len       = '0;
        prd_sum       = '0;
        prd_matched   = 1'b0;
        prd_ctrl_errs = '0;
        prd_sum_errs  = '0;
        cfg_type      = METER_TYPE_RST;
        cfg_ctrl      = EXP_CONTROL_RST;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_METER_TYPE;
        i_cfg_data   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed bytes under the reset setting: noise, repeated start, a frame
        // aborted on a wrong control byte, a type byte with no start byte ahead
        // of it, then a good zero-length frame with its checksum.
        opening_rows = '{
            known_row(8'h00, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0),
            known_row(8'h68, 1'b1, 9'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0),
            known_row(8'h68, 1'b1, 9'd0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0),
            known_row(8'h20, 1'b1, 9'd1, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0),
            plain_row(8'h00), plain_row(8'hff), plain_row(8'h01), plain_row(8'h80),
            plain_row(8'h7f), plain_row(8'h55), plain_row(8'haa),
            plain_row(8'h55),
            known_row(8'hff, 1'b1, 9'd10, 1'b1, 1'b0, 1'b1, 16'd1, 16'd1),
            known_row(8'h20, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 16'd1, 16'd1),
            known_row(8'h68, 1'b1, 9'd0, 1'b0, 1'b0, 1'b0, 16'd1, 16'd1),
            plain_row(8'h20),
            plain_row(8'h00), plain_row(8'hff), plain_row(8'h01), plain_row(8'h80),
            plain_row(8'h7f), plain_row(8'h55), plain_row(8'haa),
            plain_row(8'h81),
            plain_row(8'h00),
            plain_row(8'h07),
            known_row(8'hff, 1'b1, 9'd12, 1'b1, 1'b1, 1'b0, 16'd1, 16'd1)
        };
        idle_pct = set_idle[0];
        foreach (opening_rows[k]) tx_bytes.insert(tx_bytes.size(), opening_rows[k]);

        for (int s = 0; s < SETTING_COUNT; s++) begin
            // Change the setting only once every echo is back.
            if (s != 0) begin
                wait_drained();
                write_reg(CFG_METER_TYPE, set_type[s]);
                write_reg(CFG_EXPECTED_CONTROL, set_ctrl[s]);
                @(negedge i_clk);
            end
            idle_pct = set_idle[s];
            // Reach the last byte position at least once.
            if (s == 0) queue_frame(255, FLAW_NONE);
            while (tx_bytes.size() < PHASE_BYTES) queue_random_frame();
        end

        // Drain, then keep the clock running so that any stray echo shows.
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[meter_frame_receiver] OK");
        end else begin
            $display("[meter_frame_receiver] ERROR");
        end
        $finish;
    end

endmodule
